// ----- sv/chrs_pkg.sv -----
package chrs_pkg;

	localparam int DEF_MAX_POINTS   = 4096;
	localparam int DEF_MAX_SERVERS  = 64;
	localparam int DEF_MAX_REPLICAS = 8;

	// hard limit on picks per lookup, set by the 3-bit replica_index field
	localparam int OUT_LIMIT = 8;

	localparam int POINT_W   = 32;
	localparam int SERVER_W  = 6;
	localparam int CAP_W     = 16;
	localparam int PCOUNT_W  = 13;
	localparam int SCOUNT_W  = 7;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 13;

	typedef enum logic [1:0] {
		REQ_RING_WR = 2'd0,
		REQ_CAP_WR  = 2'd1,
		REQ_LOOKUP  = 2'd2,
		REQ_NONE    = 2'd3
	} req_type_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_POINT_COUNT = 2'd0,
		REG_SERVER_COUNT = 2'd1,
		REG_CAP_ENABLE  = 2'd2,
		REG_UNUSED      = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		STATUS_OK        = 1'b0,
		STATUS_EXHAUSTED = 1'b1
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_WALK_RD,
		ST_WALK_CAP,
		ST_WALK_CHK,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]          req_type;
		logic [11:0]         entry_index;
		logic [POINT_W-1:0]  entry_point;
		logic [SERVER_W-1:0] server_select;
		logic [CAP_W-1:0]    capacity_value;
		logic [POINT_W-1:0]  key_position;
		logic [3:0]          replica_count;
	} req_item_t;

	typedef struct packed {
		logic [SERVER_W-1:0] pick_server;
		logic [SERVER_W-1:0] lead_server;
		logic [2:0]          replica_index;
		logic                status;
		logic                last;
	} result_item_t;

endpackage

// ----- sv/chrs_ring_mem.sv -----
module chrs_ring_mem
	import chrs_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_POINTS
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [POINT_W-1:0]       wr_point,
	input  logic [SERVER_W-1:0]      wr_server,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [POINT_W-1:0]       rd_point,
	output logic [SERVER_W-1:0]      rd_server
);

	logic [POINT_W+SERVER_W-1:0] mem [DEPTH];
	logic [POINT_W+SERVER_W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_point, wr_server};
		end
		rd_q <= mem[rd_addr];
	end

	assign rd_point  = rd_q[POINT_W+SERVER_W-1:SERVER_W];
	assign rd_server = rd_q[SERVER_W-1:0];

endmodule

// ----- sv/chrs_cap_mem.sv -----
module chrs_cap_mem
	import chrs_pkg::*;
#(
	parameter int DEPTH = DEF_MAX_SERVERS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [CAP_W-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [CAP_W-1:0]         rd_data
);

	logic [CAP_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [CAP_W-1:0] rd_q;

	// entries not written since reset read as zero capacity
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= valid_q[rd_addr] ? mem[rd_addr] : '0;
	end

	assign rd_data = rd_q;

endmodule

// ----- sv/consistent_hash_replica_select_core.sv -----
// Consistent-hash ring lookup with replica selection.
// Input channel: an item is taken when start is high and busy is low. req_type picks
// a ring entry write, a server capacity write, or a lookup of key_position.
// Writes finish in the accept cycle; busy stays low and no result follows.
// A lookup raises busy while it runs. It scans ring entries from 0
// for the first point at or above the key (states SCAN_RD then SCAN_CHK per entry,
// entry 0 if none matches), then walks forward with wrap-around through WALK_RD,
// WALK_CAP and WALK_CHK per entry, one ring memory read and one capacity memory read
// per step. Each pick then comes out on result with result_strobe high for one
// cycle, one per cycle, the final one flagged by last; a short ring ends with a
// status=1 error result. The scan covers entries 0 up to the start entry, or all
// point_count entries when no point is at or above the key, and at most
// point_count+1 entries are walked. Busy drops in the cycle that carries the last
// result, so the next item can be taken at the edge that takes that result.
// The receiver cannot stall: results are not held. Configuration writes on
// cfg_wr_en/cfg_index/cfg_wdata take effect at once; the user must make them only
// while idle, and the block itself does not enforce this.
// Reset clears the sequencer, the registers (1 point, 1 server, capacity off) and
// all server capacities; ring entries hold nothing until written.
module consistent_hash_replica_select_core
	import chrs_pkg::*;
#(
	parameter int MAX_POINTS   = DEF_MAX_POINTS,
	parameter int MAX_SERVERS  = DEF_MAX_SERVERS,
	parameter int MAX_REPLICAS = DEF_MAX_REPLICAS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  req_item_t            req,
	output logic                 result_strobe,
	output result_item_t         result,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_wdata
);

	localparam int PW   = $clog2(MAX_POINTS);
	localparam int CW   = $clog2(MAX_POINTS + 2);
	localparam int SW   = $clog2(MAX_SERVERS);
	localparam int NSW  = $clog2(MAX_SERVERS + 1);
	localparam int WMAX = (MAX_REPLICAS < OUT_LIMIT) ? MAX_REPLICAS : OUT_LIMIT;
	localparam int KW   = (WMAX > 1) ? $clog2(WMAX) : 1;

	state_t state_q, state_d;

	logic [PCOUNT_W-1:0] pc_q;
	logic [SCOUNT_W-1:0] sc_q;
	logic                cen_q;

	logic [POINT_W-1:0]  pos_q;
	logic [3:0]          want_q;
	logic [CW-1:0]       np_q;
	logic [NSW-1:0]      ns_q;
	logic [CW-1:0]       idx_q;
	logic [CW-1:0]       e_q;
	logic [CW-1:0]       vis_q;
	logic [3:0]          picks_q;
	logic [3:0]          k_q;
	logic [SERVER_W-1:0] lead_q;
	logic [SERVER_W-1:0] srv_q;
	logic [MAX_SERVERS-1:0] seen_q;
	logic [SERVER_W-1:0] sids_q [WMAX];
	result_item_t        result_q;
	logic                strobe_q;

	logic [POINT_W-1:0]  ring_point;
	logic [SERVER_W-1:0] ring_server;
	logic [CAP_W-1:0]    cap_rd;

	logic                ring_wr_en;
	logic [PW-1:0]       ring_rd_addr;
	logic                cap_wr_en;
	logic [SW-1:0]       cap_wr_addr;
	logic [CAP_W-1:0]    cap_wr_data;

	logic                accept;
	logic                eligible;
	logic                take;
	logic                pick;
	logic [CW-1:0]       vis_n;
	logic [3:0]          picks_n;
	logic [CW-1:0]       e_n;
	logic [CW-1:0]       np_sat;
	logic [NSW-1:0]      ns_sat;
	logic [3:0]          want_sat;
	result_item_t        res_d;
	logic                strobe_d;
	logic                emit_pick;
	logic                emit_last;

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	// saturate the counts at lookup start
	always_comb begin
		if (pc_q == '0) begin
			np_sat = CW'(1);
		end else if (32'(pc_q) > MAX_POINTS) begin
			np_sat = CW'(MAX_POINTS);
		end else begin
			np_sat = CW'(pc_q);
		end
		if (sc_q == '0) begin
			ns_sat = NSW'(1);
		end else if (32'(sc_q) > MAX_SERVERS) begin
			ns_sat = NSW'(MAX_SERVERS);
		end else begin
			ns_sat = NSW'(sc_q);
		end
		if (req.replica_count == '0) begin
			want_sat = 4'd1;
		end else if (32'(req.replica_count) > WMAX) begin
			want_sat = 4'(WMAX);
		end else begin
			want_sat = req.replica_count;
		end
	end

	assign ring_wr_en = accept && (req.req_type == REQ_RING_WR)
		&& (32'(req.entry_index) < MAX_POINTS);
	assign ring_rd_addr = (state_q == ST_SCAN_RD) ? idx_q[PW-1:0] : e_q[PW-1:0];

	chrs_ring_mem #(
		.DEPTH(MAX_POINTS)
	) u_ring (
		.clk      (clk),
		.wr_en    (ring_wr_en),
		.wr_addr  (PW'(req.entry_index)),
		.wr_point (req.entry_point),
		.wr_server(req.server_select),
		.rd_addr  (ring_rd_addr),
		.rd_point (ring_point),
		.rd_server(ring_server)
	);

	// walk step decisions
	assign eligible = (32'(srv_q) < 32'(ns_q));
	assign take     = eligible && !seen_q[SW'(srv_q)];
	assign pick     = take && (!cen_q || (cap_rd != '0));
	assign vis_n    = vis_q + CW'(1);
	assign picks_n  = picks_q + (pick ? 4'd1 : 4'd0);
	assign e_n      = (e_q == np_q - CW'(1)) ? '0 : e_q + CW'(1);

	always_comb begin
		if (state_q == ST_WALK_CHK) begin
			cap_wr_en   = pick && cen_q;
			cap_wr_addr = SW'(srv_q);
			cap_wr_data = cap_rd - CAP_W'(1);
		end else begin
			cap_wr_en   = accept && (req.req_type == REQ_CAP_WR)
				&& (32'(req.server_select) < MAX_SERVERS);
			cap_wr_addr = SW'(req.server_select);
			cap_wr_data = req.capacity_value;
		end
	end

	chrs_cap_mem #(
		.DEPTH(MAX_SERVERS)
	) u_cap (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cap_wr_en),
		.wr_addr(cap_wr_addr),
		.wr_data(cap_wr_data),
		.rd_addr(SW'(ring_server)),
		.rd_data(cap_rd)
	);

	assign emit_pick = (k_q < picks_q);
	assign emit_last = (picks_q == want_q) && (k_q == picks_q - 4'd1);

	always_comb begin
		state_d  = state_q;
		strobe_d = 1'b0;
		res_d    = result_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (req.req_type == REQ_LOOKUP)) begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SCAN_RD: begin
				state_d = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if ((ring_point >= pos_q) || (idx_q == np_q - CW'(1))) begin
					state_d = ST_WALK_RD;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_WALK_RD: begin
				state_d = ST_WALK_CAP;
			end
			ST_WALK_CAP: begin
				state_d = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				if ((vis_n <= np_q) && (picks_n < want_q)) begin
					state_d = ST_WALK_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				strobe_d            = 1'b1;
				res_d.lead_server   = lead_q;
				res_d.replica_index = 3'(k_q);
				if (emit_pick) begin
					res_d.pick_server = sids_q[KW'(k_q)];
					res_d.status      = STATUS_OK;
					res_d.last        = emit_last;
					if (emit_last) begin
						state_d = ST_IDLE;
					end
				end else begin
					res_d.pick_server = '0;
					res_d.status      = STATUS_EXHAUSTED;
					res_d.last        = 1'b1;
					state_d           = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			strobe_q <= 1'b0;
			pc_q     <= PCOUNT_W'(1);
			sc_q     <= SCOUNT_W'(1);
			cen_q    <= 1'b0;
			picks_q  <= '0;
			seen_q   <= '0;
		end else begin
			state_q  <= state_d;
			strobe_q <= strobe_d;
			if (cfg_wr_en) begin
				unique case (cfg_index)
					REG_POINT_COUNT:  pc_q  <= cfg_wdata;
					REG_SERVER_COUNT: sc_q  <= cfg_wdata[SCOUNT_W-1:0];
					REG_CAP_ENABLE:   cen_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (accept && (req.req_type == REQ_LOOKUP)) begin
				picks_q <= '0;
				seen_q  <= '0;
			end else if (state_q == ST_WALK_CHK) begin
				picks_q <= picks_n;
				if (take) begin
					seen_q[SW'(srv_q)] <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= res_d;
		if (accept && (req.req_type == REQ_LOOKUP)) begin
			pos_q  <= req.key_position;
			want_q <= want_sat;
			np_q   <= np_sat;
			ns_q   <= ns_sat;
			idx_q  <= '0;
		end
		if (state_q == ST_SCAN_CHK) begin
			vis_q <= '0;
			if (ring_point >= pos_q) begin
				e_q <= idx_q;
			end else if (idx_q == np_q - CW'(1)) begin
				e_q <= '0;
			end else begin
				idx_q <= idx_q + CW'(1);
			end
		end
		if (state_q == ST_WALK_CAP) begin
			srv_q <= ring_server;
			// first entry walked is the start entry
			if (vis_q == '0) begin
				lead_q <= ring_server;
			end
		end
		if (state_q == ST_WALK_CHK) begin
			vis_q <= vis_n;
			e_q   <= e_n;
			if (pick) begin
				sids_q[KW'(picks_q)] <= srv_q;
			end
			k_q <= '0;
		end
		if (state_q == ST_EMIT) begin
			k_q <= k_q + 4'd1;
		end
	end

	assign result_strobe = strobe_q;
	assign result        = result_q;

`ifndef SYNTHESIS
	a_picks_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_RD || state_q == ST_EMIT) |-> (picks_q <= want_q))
		else $error("picks exceed wanted replica count");

	a_seen_covers_picks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> ($countones(seen_q) >= 32'(picks_q)))
		else $error("pick made without marking its server");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.status == STATUS_EXHAUSTED) |-> result.last)
		else $error("exhausted result not marked last");

	a_emit_ends_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && result.last) |-> (state_q == ST_IDLE))
		else $error("sequencer still busy after last result");

	a_cap_dec_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK_CHK && cap_wr_en) |-> (cen_q && cap_rd != '0))
		else $error("capacity decrement without available capacity");
`endif

endmodule
